// ===== rtl/kavf_pkg.sv =====
// ----------------------------------------------------------------------------
// kavf_pkg
// Shared types, constants and the micro-program of the altitude/velocity
// tracking filter.
// ----------------------------------------------------------------------------
package kavf_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DivBits   = DataWidth + FracBits;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumSteps  = 26;
  localparam int unsigned StepW     = $clog2(NumSteps);

  typedef logic signed [DataWidth-1:0] word_t;

  localparam word_t QOne = word_t'(1) <<< FracBits;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MEAS_NOISE = 3'd0,
    CFG_ALT_NOISE  = 3'd1,
    CFG_VEL_NOISE  = 3'd2,
    CFG_START_ALT  = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [4:0] {
    RG_ALT, RG_VEL, RG_PAA, RG_PAV, RG_PVA, RG_PVV,
    RG_MEAS, RG_DT, RG_P00, RG_P01, RG_P10, RG_P11,
    RG_S, RG_K0, RG_K1, RG_TMP,
    RG_NOISE, RG_QA, RG_QV, RG_ONE
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    reg_e dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MULRND,
    ST_DIVW,
    ST_FLUSH
  } seq_state_e;

  // Predict, form innovation and gains, then correct state and covariance.
  function automatic uop_t step_uop(input logic [StepW-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = '{OP_MUL, RG_DT,   RG_VEL,  RG_TMP};
      5'd1:    u = '{OP_ADD, RG_ALT,  RG_TMP,  RG_ALT};
      5'd2:    u = '{OP_MUL, RG_DT,   RG_PVV,  RG_TMP};
      5'd3:    u = '{OP_ADD, RG_PAV,  RG_TMP,  RG_P01};
      5'd4:    u = '{OP_ADD, RG_PVA,  RG_TMP,  RG_P10};
      5'd5:    u = '{OP_MUL, RG_DT,   RG_PVA,  RG_TMP};
      5'd6:    u = '{OP_ADD, RG_PAA,  RG_TMP,  RG_P00};
      5'd7:    u = '{OP_MUL, RG_DT,   RG_P01,  RG_TMP};
      5'd8:    u = '{OP_ADD, RG_P00,  RG_TMP,  RG_P00};
      5'd9:    u = '{OP_ADD, RG_P00,  RG_QA,   RG_P00};
      5'd10:   u = '{OP_ADD, RG_PVV,  RG_QV,   RG_P11};
      5'd11:   u = '{OP_SUB, RG_MEAS, RG_ALT,  RG_MEAS};
      5'd12:   u = '{OP_ADD, RG_P00,  RG_NOISE, RG_S};
      5'd13:   u = '{OP_DIV, RG_P00,  RG_S,    RG_K0};
      5'd14:   u = '{OP_DIV, RG_P10,  RG_S,    RG_K1};
      5'd15:   u = '{OP_MUL, RG_K0,   RG_MEAS, RG_TMP};
      5'd16:   u = '{OP_ADD, RG_ALT,  RG_TMP,  RG_ALT};
      5'd17:   u = '{OP_MUL, RG_K1,   RG_MEAS, RG_TMP};
      5'd18:   u = '{OP_ADD, RG_VEL,  RG_TMP,  RG_VEL};
      5'd19:   u = '{OP_SUB, RG_ONE,  RG_K0,   RG_S};
      5'd20:   u = '{OP_MUL, RG_S,    RG_P00,  RG_PAA};
      5'd21:   u = '{OP_MUL, RG_S,    RG_P01,  RG_PAV};
      5'd22:   u = '{OP_MUL, RG_K1,   RG_P00,  RG_TMP};
      5'd23:   u = '{OP_SUB, RG_P10,  RG_TMP,  RG_PVA};
      5'd24:   u = '{OP_MUL, RG_K1,   RG_P01,  RG_TMP};
      5'd25:   u = '{OP_SUB, RG_P11,  RG_TMP,  RG_PVV};
      default: u = '{OP_ADD, RG_TMP,  RG_TMP,  RG_TMP};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/kavf_div.sv =====
// ----------------------------------------------------------------------------
// kavf_div
// Serial fixed-point divider, two quotient bits a cycle, rounded to nearest
// and saturated to the word range. Divisor must be positive.
// ----------------------------------------------------------------------------
module kavf_div import kavf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  done_o,
  output word_t quo_o
);

  localparam int unsigned CntW = $clog2(DivBits / 2 + 1);

  logic [DivBits-1:0] dvd_q, dvd_d;
  logic [DivBits-1:0] quo_q, quo_d;
  logic [DataWidth:0] rem_q, rem_d;
  logic [DataWidth:0] den_q;
  logic               neg_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;

  logic [DataWidth-1:0] mag;
  logic [DataWidth:0]   r_tmp;
  logic [DataWidth:0]   half_gap;
  logic [DivBits:0]     q_rnd;
  logic [DivBits:0]     lim;
  logic [DataWidth-1:0] q_sat;

  assign mag = num_i[DataWidth-1] ? DataWidth'(-num_i) : DataWidth'(num_i);

  // Two restoring steps per cycle.
  always_comb begin
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      r_tmp = {rem_d[DataWidth-1:0], dvd_d[DivBits-1]};
      dvd_d = {dvd_d[DivBits-2:0], 1'b0};
      if (r_tmp >= den_q) begin
        rem_d = r_tmp - den_q;
        quo_d = {quo_d[DivBits-2:0], 1'b1};
      end else begin
        rem_d = r_tmp;
        quo_d = {quo_d[DivBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivBits / 2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, FracBits'(0)};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= {1'b0, den_i};
      neg_q <= num_i[DataWidth-1];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Round half up on the remainder, then clamp.
  always_comb begin
    half_gap = den_q - rem_q;
    q_rnd    = {1'b0, quo_q} + ((rem_q >= half_gap) ? (DivBits+1)'(1) : '0);
    lim      = neg_q ? ((DivBits+1)'(1) << (DataWidth-1))
                     : (((DivBits+1)'(1) << (DataWidth-1)) - 1'b1);
    q_sat    = (q_rnd > lim) ? lim[DataWidth-1:0] : q_rnd[DataWidth-1:0];
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? word_t'(-q_sat) : word_t'(q_sat);

endmodule

// ===== rtl/kalman_altitude_velocity_filter_core.sv =====
// ----------------------------------------------------------------------------
// kalman_altitude_velocity_filter_core
// Two-state constant-velocity tracking filter for altitude and climb rate.
// ----------------------------------------------------------------------------
// Each item (altitude reading, time step) runs a 26-step micro-program on one
// shared 32x32 multiplier, one saturating adder and a serial divider. An add
// writes straight from the adder, a multiply registers its product and rounds
// it in a state of its own, and each gain division waits for the divider, or
// writes a zero gain when the innovation variance is not positive; the two
// divisions take most of an item's time. The input is not ready while an item
// is in work, so the next item is accepted only after the previous one is
// finished; a finished result waits in an output register and does not stop
// the next item. Writing any configuration register (indices 0 to 3) resets
// the estimate: covariance to identity, velocity to zero, altitude to the
// start value. Write configuration only while the block is idle.
module kalman_altitude_velocity_filter_core import kavf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // measured_altitude[31:0], time_step[47:32]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // est_altitude[31:0], est_velocity[63:32]
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DataWidth-1:0] cfg_wdata_i
);

  seq_state_e state_q, state_d;
  logic [StepW-1:0] step_q;

  logic [DataWidth-2:0] noise_q, qa_q, qv_q;
  word_t                start_q;
  word_t alt_q, vel_q, paa_q, pav_q, pva_q, pvv_q;
  word_t meas_q, dt_q, p00_q, p01_q, p10_q, p11_q, s_q, k0_q, k1_q, tmp_q;

  logic [63:0] prod_q;
  logic        prod_neg_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;

  uop_t  uop;
  word_t opa, opb, alu_res, wr_data, rnd_res, div_res;
  logic  wr_en, last_step, s_nonpos, div_start, div_done, mul_cap;
  logic  accept, cfg_hit;

  assign uop       = step_uop(step_q);
  assign last_step = (step_q == StepW'(NumSteps - 1));
  assign s_nonpos  = (s_q <= 0);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_hit   = cfg_we_i && (cfg_idx_i <= CFG_START_ALT);

  function automatic word_t rd(input reg_e sel, input word_t a, v, paa, pav, pva,
                               pvv, ms, dt, p00, p01, p10, p11, s, k0, k1, t,
                               input logic [DataWidth-2:0] nz, qa, qv);
    word_t r;
    case (sel)
      RG_ALT:   r = a;
      RG_VEL:   r = v;
      RG_PAA:   r = paa;
      RG_PAV:   r = pav;
      RG_PVA:   r = pva;
      RG_PVV:   r = pvv;
      RG_MEAS:  r = ms;
      RG_DT:    r = dt;
      RG_P00:   r = p00;
      RG_P01:   r = p01;
      RG_P10:   r = p10;
      RG_P11:   r = p11;
      RG_S:     r = s;
      RG_K0:    r = k0;
      RG_K1:    r = k1;
      RG_TMP:   r = t;
      RG_NOISE: r = word_t'({1'b0, nz});
      RG_QA:    r = word_t'({1'b0, qa});
      RG_QV:    r = word_t'({1'b0, qv});
      RG_ONE:   r = QOne;
      default:  r = '0;
    endcase
    return r;
  endfunction

  assign opa = rd(uop.src_a, alt_q, vel_q, paa_q, pav_q, pva_q, pvv_q, meas_q, dt_q,
                  p00_q, p01_q, p10_q, p11_q, s_q, k0_q, k1_q, tmp_q, noise_q, qa_q, qv_q);
  assign opb = rd(uop.src_b, alt_q, vel_q, paa_q, pav_q, pva_q, pvv_q, meas_q, dt_q,
                  p00_q, p01_q, p10_q, p11_q, s_q, k0_q, k1_q, tmp_q, noise_q, qa_q, qv_q);

  // Saturating add / subtract.
  logic signed [DataWidth:0] sum;
  always_comb begin
    if (uop.op == OP_SUB) sum = {opa[DataWidth-1], opa} - {opb[DataWidth-1], opb};
    else                  sum = {opa[DataWidth-1], opa} + {opb[DataWidth-1], opb};
    if (sum[DataWidth] != sum[DataWidth-1]) begin
      alu_res = sum[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
    end else begin
      alu_res = sum[DataWidth-1:0];
    end
  end

  // Multiplier: magnitudes, registered product, round and clamp next cycle.
  logic [DataWidth-1:0] mag_a, mag_b;
  logic [63:0]          prod_r;
  logic [63-FracBits:0] prod_sh, prod_lim;
  logic [DataWidth-1:0] prod_sat;
  assign mag_a = opa[DataWidth-1] ? DataWidth'(-opa) : DataWidth'(opa);
  assign mag_b = opb[DataWidth-1] ? DataWidth'(-opb) : DataWidth'(opb);

  always_comb begin
    prod_r   = prod_q + (64'd1 << (FracBits - 1));
    prod_sh  = prod_r[63:FracBits];
    prod_lim = prod_neg_q ? ((64-FracBits)'(1) << (DataWidth-1))
                          : (((64-FracBits)'(1) << (DataWidth-1)) - 1'b1);
    prod_sat = (prod_sh > prod_lim) ? prod_lim[DataWidth-1:0] : prod_sh[DataWidth-1:0];
    rnd_res  = prod_neg_q ? word_t'(-prod_sat) : word_t'(prod_sat);
  end

  always_ff @(posedge clk_i) begin
    if (mul_cap) begin
      prod_q     <= 64'(mag_a) * 64'(mag_b);
      prod_neg_q <= opa[DataWidth-1] ^ opb[DataWidth-1];
    end
  end

  kavf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (opa),
    .den_i  (opb),
    .done_o (div_done),
    .quo_o  (div_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: begin
        case (uop.op)
          OP_MUL:  state_d = ST_MULRND;
          OP_DIV:  state_d = s_nonpos ? (last_step ? ST_FLUSH : ST_EXEC) : ST_DIVW;
          default: state_d = last_step ? ST_FLUSH : ST_EXEC;
        endcase
      end
      ST_MULRND: state_d = last_step ? ST_FLUSH : ST_EXEC;
      ST_DIVW:   if (div_done) state_d = last_step ? ST_FLUSH : ST_EXEC;
      ST_FLUSH:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    wr_en     = 1'b0;
    wr_data   = alu_res;
    mul_cap   = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_EXEC: begin
        case (uop.op)
          OP_MUL:  mul_cap = 1'b1;
          OP_DIV: begin
            if (s_nonpos) begin
              wr_en   = 1'b1;
              wr_data = '0;
            end else begin
              div_start = 1'b1;
            end
          end
          default: wr_en = 1'b1;
        endcase
      end
      ST_MULRND: begin
        wr_en   = 1'b1;
        wr_data = rnd_res;
      end
      ST_DIVW: begin
        wr_en   = div_done;
        wr_data = div_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) step_q <= '0;
      else if (wr_en && !last_step) step_q <= step_q + 1'b1;
    end
  end

  // Configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= (DataWidth-1)'(65536);
      qa_q    <= (DataWidth-1)'(66);
      qv_q    <= (DataWidth-1)'(655);
      start_q <= '0;
      alt_q   <= '0;
      vel_q   <= '0;
      paa_q   <= QOne;
      pav_q   <= '0;
      pva_q   <= '0;
      pvv_q   <= QOne;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        CFG_MEAS_NOISE: noise_q <= cfg_wdata_i[DataWidth-2:0];
        CFG_ALT_NOISE:  qa_q    <= cfg_wdata_i[DataWidth-2:0];
        CFG_VEL_NOISE:  qv_q    <= cfg_wdata_i[DataWidth-2:0];
        default:        start_q <= cfg_wdata_i;
      endcase
      alt_q <= (cfg_idx_i == CFG_START_ALT) ? cfg_wdata_i : start_q;
      vel_q <= '0;
      paa_q <= QOne;
      pav_q <= '0;
      pva_q <= '0;
      pvv_q <= QOne;
    end else if (wr_en) begin
      case (uop.dst)
        RG_ALT: alt_q <= wr_data;
        RG_VEL: vel_q <= wr_data;
        RG_PAA: paa_q <= wr_data;
        RG_PAV: pav_q <= wr_data;
        RG_PVA: pva_q <= wr_data;
        RG_PVV: pvv_q <= wr_data;
        default: ;
      endcase
    end
  end

  // Scratch registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= s_axis_tdata[31:0];
      dt_q   <= word_t'({16'd0, s_axis_tdata[47:32]});
    end else if (wr_en) begin
      case (uop.dst)
        RG_MEAS: meas_q <= wr_data;
        RG_P00:  p00_q  <= wr_data;
        RG_P01:  p01_q  <= wr_data;
        RG_P10:  p10_q  <= wr_data;
        RG_P11:  p11_q  <= wr_data;
        RG_S:    s_q    <= wr_data;
        RG_K0:   k0_q   <= wr_data;
        RG_K1:   k1_q   <= wr_data;
        RG_TMP:  tmp_q  <= wr_data;
        default: ;
      endcase
    end
  end

  // Output register: load on flush, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FLUSH && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLUSH && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {vel_q, alt_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/kavf_chk.sv =====
// ----------------------------------------------------------------------------
// kavf_chk
// Port-level checks of the tracking filter, bound to the top level.
// ----------------------------------------------------------------------------
module kavf_chk import kavf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result not held");

  // An accepted item keeps the input closed right after its acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened too early");

  // A new result only appears once the input has reopened.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while item in work");

endmodule

bind kalman_altitude_velocity_filter_core kavf_chk u_kavf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== verif/kavf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kavf_checker
// Watches the item and result channels of the altitude/velocity filter,
// tracks the filter state with its own fixed-point arithmetic and compares
// every result with the oldest predicted estimate.
// ----------------------------------------------------------------------------
module kavf_checker import kavf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [63:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DataWidth-1:0] cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   estimates_seen_o
);

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam longint One  = 64'sd65536;

  longint meas_noise, alt_noise, vel_noise, start_alt;
  longint alt_st, vel_st, paa, pav, pva, pvv;
  logic [63:0] estimate_q[$];

  function automatic longint sat(input longint v);
    return v < QMin ? QMin : (v > QMax ? QMax : v);
  endfunction

  // Exact product, round half away from zero, saturate.
  function automatic longint fmul(input longint a, input longint b);
    logic signed [127:0] p;
    logic [127:0] m;
    p = 128'(a) * 128'(b);
    m = p < 0 ? -p : p;
    m = (m + 128'd32768) >> 16;
    if (m > 128'd2147483648) m = 128'd2147483648;
    return p < 0 ? sat(-longint'(m)) : sat(longint'(m));
  endfunction

  // n / d, d > 0, round half up on magnitude, sign of n, saturate.
  function automatic longint fdiv(input longint n, input longint d);
    logic [127:0] m, q, r;
    m = (n < 0 ? 128'(-n) : 128'(n)) << 16;
    q = m / 128'(d);
    r = m % 128'(d);
    if (r >= 128'(d) - r) q = q + 1;
    if (q > 128'd2147483648) q = 128'd2147483648;
    return n < 0 ? sat(-longint'(q)) : sat(longint'(q));
  endfunction

  task automatic reinit_filter();
    alt_st = start_alt; vel_st = 0;
    paa = One; pav = 0; pva = 0; pvv = One;
  endtask

  task automatic predict_estimate(input logic [47:0] item);
    longint zm, dt, t, p00, p01, p10, p11, y, s, k0, k1, omk;
    zm = longint'($signed(item[31:0]));
    dt = longint'(item[47:32]);
    alt_st = sat(alt_st + fmul(dt, vel_st));
    t   = fmul(dt, pvv);
    p01 = sat(pav + t);
    p10 = sat(pva + t);
    p00 = sat(paa + fmul(dt, pva));
    p00 = sat(p00 + fmul(dt, p01));
    p00 = sat(p00 + alt_noise);
    p11 = sat(pvv + vel_noise);
    y = sat(zm - alt_st);
    s = sat(p00 + meas_noise);
    k0 = 0; k1 = 0;
    // hold the predicted values when the innovation variance is not positive
    if (s > 0) begin
      k0 = fdiv(p00, s);
      k1 = fdiv(p10, s);
    end
    alt_st = sat(alt_st + fmul(k0, y));
    vel_st = sat(vel_st + fmul(k1, y));
    omk = sat(One - k0);
    paa = fmul(omk, p00);
    pav = fmul(omk, p01);
    pva = sat(p10 - fmul(k1, p00));
    pvv = sat(p11 - fmul(k1, p01));
    estimate_q.push_back({vel_st[31:0], alt_st[31:0]});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      meas_noise = 65536; alt_noise = 66; vel_noise = 655; start_alt = 0;
      reinit_filter();
      estimate_q.delete();
      fail_count_o <= 0;
      estimates_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MEAS_NOISE: meas_noise = longint'(cfg_wdata_i[30:0]);
          CFG_ALT_NOISE:  alt_noise  = longint'(cfg_wdata_i[30:0]);
          CFG_VEL_NOISE:  vel_noise  = longint'(cfg_wdata_i[30:0]);
          CFG_START_ALT:  start_alt  = longint'($signed(cfg_wdata_i));
          default: ;
        endcase
        if (cfg_idx_i <= CFG_START_ALT) reinit_filter();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        estimates_seen_o <= estimates_seen_o + 1;
        if (estimate_q.size() == 0) begin
          $error("estimate with none expected: %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = estimate_q.pop_front();
          if (want[31:0] !== m_axis_tdata[31:0]) begin
            $error("est_altitude: expected %h, got %h", want[31:0], m_axis_tdata[31:0]);
            fail_count_o <= fail_count_o + 1;
          end
          if (want[63:32] !== m_axis_tdata[63:32]) begin
            $error("est_velocity: expected %h, got %h", want[63:32], m_axis_tdata[63:32]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_estimate(s_axis_tdata);
    end
    pending_o = estimate_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the altitude/velocity tracking filter: directed
// extremes, then random reading streams under several idling phases and
// configuration settings; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import kavf_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;   // measured_altitude[31:0], time_step[47:32]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [63:0]          m_axis_tdata;        // est_altitude[31:0], est_velocity[63:32]
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DataWidth-1:0] cfg_wdata_i = '0;

  int fail_count, pending, estimates_seen;
  int send_idle_pct, recv_stall_pct;
  int items_sent;
  logic [31:0] track_alt;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  kalman_altitude_velocity_filter_core dut (.*);

  kavf_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending),
    .estimates_seen_o(estimates_seen)
  );

  // Receiver stalls at the phase's rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold valid until the item is accepted, then drop it before the next item.
  task automatic send_reading(input logic [31:0] alt, input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, alt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_config();
    write_reg(CFG_MEAS_NOISE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 400000));
    write_reg(CFG_ALT_NOISE, ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 3000));
    write_reg(CFG_VEL_NOISE, ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 30000));
    write_reg(CFG_START_ALT, $urandom);
  endtask

  // Mostly a smooth climb with noise, sometimes wild readings and steps.
  task automatic random_reading();
    logic [31:0] alt;
    logic [15:0] dt;
    dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300, 9000));
    track_alt = track_alt + 32'($urandom_range(0, 4000)) - 32'd2000;
    alt = track_alt + 32'($urandom_range(0, 60000)) - 32'd30000;
    if ($urandom_range(19) == 0) alt = $urandom;
    send_reading(alt, dt);
  endtask

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0; items_sent = 0; track_alt = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes under reset settings.
    send_reading(32'h0000_0000, 16'h0000);
    send_reading(32'h7fff_ffff, 16'hffff);
    send_reading(32'h8000_0000, 16'hffff);
    send_reading(32'h7fff_ffff, 16'h0001);
    send_reading(32'h8000_0000, 16'h8000);
    send_reading(32'h5555_5555, 16'haaaa);
    send_reading(32'haaaa_aaaa, 16'h5555);
    drain();
    // Zero measurement noise: no innovation margin.
    write_reg(CFG_MEAS_NOISE, 32'h0000_0000);
    send_reading(32'h0001_0000, 16'h1000);
    send_reading(32'h0000_0000, 16'h0000);
    send_reading(32'hffff_0000, 16'hffff);
    drain();
    // Largest noise and start altitude: saturation everywhere.
    write_reg(CFG_MEAS_NOISE, 32'hffff_ffff);
    write_reg(CFG_ALT_NOISE, 32'h7fff_ffff);
    write_reg(CFG_VEL_NOISE, 32'h7fff_ffff);
    write_reg(CFG_START_ALT, 32'h7fff_ffff);
    send_reading(32'h8000_0000, 16'hffff);
    send_reading(32'h7fff_ffff, 16'hffff);
    send_reading(32'h0000_0000, 16'hffff);
    drain();
    // Non-positive innovation variance: minimum R with saturated covariance.
    write_reg(CFG_MEAS_NOISE, 32'h0000_0001);
    write_reg(CFG_START_ALT, 32'h8000_0000);
    send_reading(32'h7fff_ffff, 16'hffff);
    send_reading(32'h8000_0000, 16'hffff);
    send_reading(32'h1234_5678, 16'hffff);
    // Index out of range: ignored.
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd5; cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_reading(32'h0000_8000, 16'h0100);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (phase == 4) begin
        write_reg(CFG_MEAS_NOISE, 32'h0000_0001);
        write_reg(CFG_ALT_NOISE, 32'h0000_0000);
        write_reg(CFG_VEL_NOISE, 32'h0000_0000);
      end else begin
        random_config();
      end
      track_alt = $urandom;
      for (int n = 0; n < 172; n++) begin
        random_reading();
        // let the pipeline empty once mid-phase
        if (n == 86) while (pending != 0) @(posedge clk_i);
      end
      drain();
    end

    $display("tb_top: %0d readings sent, %0d estimates checked over 8 idling/config phases",
             items_sent, estimates_seen);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kavf_pkg.sv
rtl/kavf_div.sv
rtl/kalman_altitude_velocity_filter_core.sv
rtl/kavf_chk.sv
verif/kavf_checker.sv
verif/tb_top.sv
